// ===== design/sparse_matrix_triple_store_top_macros.svh =====
// Assertion macros for the sparse matrix triple store.
// Included by the top level; no other dependencies.
`ifndef SPARSE_MATRIX_TRIPLE_STORE_TOP_MACROS_SVH
`define SPARSE_MATRIX_TRIPLE_STORE_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SMTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sparse store assertion failed");
// next-cycle implication
`define SMTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sparse store assertion failed");
`else
`define SMTS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SMTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/smts_pkg.sv =====
// Shared types and codes for the sparse matrix triple store.
// No dependencies; imported by smts_match and the top level.
package smts_pkg;

   localparam int DATA_W    = 32;
   localparam int COORD_W   = 8;
   localparam int DIM_REG_W = 7;

   // request codes
   localparam logic [1:0] REQ_PUT         = 2'd0;
   localparam logic [1:0] REQ_GET         = 2'd1;
   localparam logic [1:0] REQ_SET_DEFAULT = 2'd2;
   localparam logic [1:0] REQ_NOP         = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [1:0] CSR_NUM_COLS = 2'd1;

   typedef struct packed {
      logic [1:0]                req_type;
      logic [COORD_W-1:0]        row;
      logic [COORD_W-1:0]        col;
      logic signed [DATA_W-1:0]  value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_value;
      logic [1:0]                status;
   } rsp_item_type;

   // compare results for one table entry
   typedef struct packed {
      logic hit;
      logic free;
      logic kept;
      logic drop;
   } match_type;

endpackage

// ===== design/smts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smts_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/smts_match.sv =====
// Shared compare unit: checks one table entry against the current request.
// Depends on smts_pkg for match_type and DATA_W.
module smts_match
   import smts_pkg::*;
#(
   parameter int CRD_W = 7
) (
   input  logic [2*CRD_W+DATA_W:0] entry,
   input  logic [CRD_W-1:0]        key_row,
   input  logic [CRD_W-1:0]        key_col,
   input  logic [DATA_W-1:0]       key_value,
   input  logic [CRD_W-1:0]        lim_rows,
   input  logic [CRD_W-1:0]        lim_cols,
   output match_type               result
);

   logic              ent_valid;
   logic [CRD_W-1:0]  ent_row;
   logic [CRD_W-1:0]  ent_col;
   logic [DATA_W-1:0] ent_value;

   // entry layout, msb first: valid, row, col, value
   assign ent_valid = entry[2*CRD_W+DATA_W];
   assign ent_row   = entry[2*CRD_W+DATA_W-1 -: CRD_W];
   assign ent_col   = entry[CRD_W+DATA_W-1 -: CRD_W];
   assign ent_value = entry[DATA_W-1:0];

   always_comb begin
      result.hit  = ent_valid && (ent_row == key_row) && (ent_col == key_col);
      result.free = !ent_valid;
      result.kept = ent_valid && (ent_row <= lim_rows) && (ent_col <= lim_cols);
      result.drop = result.kept && (ent_value == key_value);
   end

endmodule

// ===== design/sparse_matrix_triple_store_top.sv =====
// Sparse matrix triple store: entry table, occupancy map and sequencer.
// Depends on smts_pkg, smts_ram, smts_match and the assertion macro header.
//
//   port group   direction  handshake          payload
//   req_*        in         req_valid/stall    req_item_type
//   rsp_*        out        rsp_valid/stall    rsp_item_type
//   csr_*        in         csr_valid/ready    csr_index, csr_data
//
// Put and get scan the entry table, a read state and a check state per entry,
//   stopping at a hit. Set-default runs a counting pass and a delete pass
//   over the table, then visits each in-range cell, reading and checking its
//   mark, and steps over used entries while looking for free slots.
// After reset a clearing pass over every address of both memories wipes
//   them; requests stall meanwhile.
// A finished result sits in the output register while the next request is
//   taken; a stalled result holds the sequencer only at its final step.
`include "sparse_matrix_triple_store_top_macros.svh"

module sparse_matrix_triple_store_top
   import smts_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int MAX_DIM  = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [DIM_REG_W-1:0] csr_data
);

   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CRD_W     = $clog2(MAX_DIM + 1);
   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int MAP_AW    = 2 * DIM_W;
   localparam int MAP_DEPTH = 1 << MAP_AW;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int AREA_W    = 2 * CRD_W;
   localparam int SUM_W     = ((CNT_W > AREA_W) ? CNT_W : AREA_W) + 2;
   localparam int CLR_DEPTH = (CAPACITY > MAP_DEPTH) ? CAPACITY : MAP_DEPTH;
   localparam int CLR_W     = $clog2(CLR_DEPTH);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_LOOK_RD  = 5'd2;
   localparam logic [4:0] S_LOOK_CHK = 5'd3;
   localparam logic [4:0] S_APPLY    = 5'd4;
   localparam logic [4:0] S_CNT_RD   = 5'd5;
   localparam logic [4:0] S_CNT_CHK  = 5'd6;
   localparam logic [4:0] S_CHECK    = 5'd7;
   localparam logic [4:0] S_WIPE     = 5'd8;
   localparam logic [4:0] S_DEL_RD   = 5'd9;
   localparam logic [4:0] S_DEL_CHK  = 5'd10;
   localparam logic [4:0] S_FILL_RD  = 5'd11;
   localparam logic [4:0] S_FILL_CHK = 5'd12;
   localparam logic [4:0] S_FREE_RD  = 5'd13;
   localparam logic [4:0] S_FREE_CHK = 5'd14;
   localparam logic [4:0] S_COMMIT   = 5'd15;
   localparam logic [4:0] S_RESULT   = 5'd16;

   typedef struct packed {
      logic              valid;
      logic [CRD_W-1:0]  row;
      logic [CRD_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } entry_type;

   logic [4:0]               state_ff, state_in;
   logic [CLR_W-1:0]         clr_ff, clr_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   req_item_type             req_ff, req_in;
   logic [DIM_REG_W-1:0]     rows_ff, rows_in;
   logic [DIM_REG_W-1:0]     cols_ff, cols_in;
   logic signed [DATA_W-1:0] default_ff, default_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic [DATA_W-1:0]        hit_val_ff, hit_val_in;
   logic                     free_found_ff, free_found_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]         total_ff, total_in;
   logic [CNT_W-1:0]         kept_ff, kept_in;
   logic [CNT_W-1:0]         dels_ff, dels_in;
   logic [AREA_W-1:0]        area_ff, area_in;
   logic [DIM_W-1:0]         r0_ff, r0_in;
   logic [DIM_W-1:0]         c0_ff, c0_in;
   rsp_item_type             res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_data_ff, rsp_data_in;

   logic [COORD_W-1:0]       rows_ext, cols_ext, nr8, nc8, nr_m1, nc_m1;
   logic [CRD_W-1:0]         nr, nc;
   logic [DIM_W-1:0]         last_r, last_c;
   logic                     in_range, region_empty, idx_last, cell_last_c, cell_last;
   logic [SUM_W-1:0]         sum_a, sum_b;
   logic                     overflow;
   logic [CRD_W-1:0]         row_m1, col_m1;
   logic [MAP_AW-1:0]        mark_addr, cell_addr;
   entry_type                put_word, fill_word;

   logic                     ent_we;
   logic [IDX_W-1:0]         ent_wa;
   entry_type                ent_wd;
   entry_type                ent_rd;
   logic                     map_we;
   logic [MAP_AW-1:0]        map_wa;
   logic [0:0]               map_wd;
   logic [0:0]               map_rd;
   match_type                m;

   smts_ram #(.WIDTH($bits(entry_type)), .DEPTH(CAPACITY)) u_entries (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_addr (idx_ff),
      .rd_data (ent_rd)
   );

   // one bit per in-range cell, set by the set-default count pass for cells that hold an entry
   smts_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_occupancy (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_addr (cell_addr),
      .rd_data (map_rd)
   );

   smts_match #(.CRD_W(CRD_W)) u_match (
      .entry     (ent_rd),
      .key_row   (req_ff.row[CRD_W-1:0]),
      .key_col   (req_ff.col[CRD_W-1:0]),
      .key_value (req_ff.value),
      .lim_rows  (nr),
      .lim_cols  (nc),
      .result    (m)
   );

   // dimensions saturated to MAX_DIM
   assign rows_ext = {1'b0, rows_ff};
   assign cols_ext = {1'b0, cols_ff};
   assign nr8 = (rows_ext > COORD_W'(MAX_DIM)) ? COORD_W'(MAX_DIM) : rows_ext;
   assign nc8 = (cols_ext > COORD_W'(MAX_DIM)) ? COORD_W'(MAX_DIM) : cols_ext;
   assign nr = nr8[CRD_W-1:0];
   assign nc = nc8[CRD_W-1:0];
   assign nr_m1 = nr8 - COORD_W'(1);
   assign nc_m1 = nc8 - COORD_W'(1);
   assign last_r = nr_m1[DIM_W-1:0];
   assign last_c = nc_m1[DIM_W-1:0];

   assign in_range = (req_data.row != '0) && (req_data.row <= nr8) &&
                     (req_data.col != '0) && (req_data.col <= nc8);
   assign region_empty = (nr8 == '0) || (nc8 == '0);
   assign idx_last = (idx_ff == IDX_W'(CAPACITY - 1));
   assign cell_last_c = (c0_ff == last_c);
   assign cell_last = cell_last_c && (r0_ff == last_r);

   // final count = total - dels + area - kept, compared without underflow
   assign sum_a = SUM_W'(total_ff) + SUM_W'(area_ff);
   assign sum_b = SUM_W'(CAPACITY) + SUM_W'(kept_ff) + SUM_W'(dels_ff);
   assign overflow = (sum_a > sum_b);

   assign row_m1 = ent_rd.row - CRD_W'(1);
   assign col_m1 = ent_rd.col - CRD_W'(1);
   assign mark_addr = {row_m1[DIM_W-1:0], col_m1[DIM_W-1:0]};
   assign cell_addr = {r0_ff, c0_ff};

   always_comb begin
      put_word.valid = 1'b1;
      put_word.row   = req_ff.row[CRD_W-1:0];
      put_word.col   = req_ff.col[CRD_W-1:0];
      put_word.value = req_ff.value;
      fill_word.valid = 1'b1;
      fill_word.row   = CRD_W'(r0_ff) + CRD_W'(1);
      fill_word.col   = CRD_W'(c0_ff) + CRD_W'(1);
      fill_word.value = default_ff;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      default_in    = default_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      total_in      = total_ff;
      kept_in       = kept_ff;
      dels_in       = dels_ff;
      area_in       = area_ff;
      r0_in         = r0_ff;
      c0_in         = c0_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ent_we        = 1'b0;
      ent_wa        = idx_ff;
      ent_wd        = '0;
      map_we        = 1'b0;
      map_wa        = cell_addr;
      map_wd        = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUM_ROWS: rows_in = csr_data;
            CSR_NUM_COLS: cols_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            ent_we = ({1'b0, clr_ff} < (CLR_W + 1)'(CAPACITY));
            ent_wa = clr_ff[IDX_W-1:0];
            map_we = ({1'b0, clr_ff} < (CLR_W + 1)'(MAP_DEPTH));
            map_wa = clr_ff[MAP_AW-1:0];
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + CLR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in            = req_data;
               idx_in            = '0;
               hit_in            = 1'b0;
               free_found_in     = 1'b0;
               total_in          = '0;
               kept_in           = '0;
               dels_in           = '0;
               area_in           = AREA_W'(nr) * AREA_W'(nc);
               res_in.read_value = '0;
               res_in.status     = ST_OK;
               unique case (req_data.req_type) inside
                  REQ_PUT, REQ_GET: begin
                     if (!in_range) begin
                        res_in.status = ST_RANGE;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_LOOK_RD;
                     end
                  end
                  REQ_SET_DEFAULT: begin
                     state_in = (req_data.value == default_ff) ? S_RESULT : S_CNT_RD;
                  end
                  default: state_in = S_RESULT;
               endcase
            end
         end
         S_LOOK_RD: state_in = S_LOOK_CHK;
         S_LOOK_CHK: begin
            if (m.hit) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               hit_val_in = ent_rd.value;
               state_in   = S_APPLY;
            end else begin
               if (m.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_last) begin
                  state_in = S_APPLY;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_LOOK_RD;
               end
            end
         end
         S_APPLY: begin
            state_in = S_RESULT;
            if (req_ff.req_type == REQ_GET) begin
               res_in.read_value = hit_ff ? hit_val_ff : default_ff;
            end else if (hit_ff) begin
               // storing the default deletes the entry
               ent_we       = 1'b1;
               ent_wa       = hit_idx_ff;
               ent_wd       = put_word;
               ent_wd.valid = (req_ff.value != default_ff);
            end else if (req_ff.value != default_ff) begin
               if (free_found_ff) begin
                  ent_we = 1'b1;
                  ent_wa = free_idx_ff;
                  ent_wd = put_word;
               end else begin
                  res_in.status = ST_FULL;
               end
            end
         end
         S_CNT_RD: state_in = S_CNT_CHK;
         S_CNT_CHK: begin
            if (ent_rd.valid) begin
               total_in = total_ff + CNT_W'(1);
            end
            if (m.kept) begin
               kept_in = kept_ff + CNT_W'(1);
               map_we  = 1'b1;
               map_wa  = mark_addr;
               map_wd  = 1'b1;
            end
            if (m.drop) begin
               dels_in = dels_ff + CNT_W'(1);
            end
            if (idx_last) begin
               state_in = S_CHECK;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_CNT_RD;
            end
         end
         S_CHECK: begin
            idx_in = '0;
            r0_in  = '0;
            c0_in  = '0;
            if (overflow) begin
               // nothing changes, but the marks must still be wiped
               res_in.status = ST_FULL;
               state_in      = region_empty ? S_RESULT : S_WIPE;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_WIPE: begin
            map_we = 1'b1;
            if (cell_last) begin
               state_in = S_RESULT;
            end else if (cell_last_c) begin
               c0_in = '0;
               r0_in = r0_ff + DIM_W'(1);
            end else begin
               c0_in = c0_ff + DIM_W'(1);
            end
         end
         S_DEL_RD: state_in = S_DEL_CHK;
         S_DEL_CHK: begin
            if (m.drop) begin
               ent_we = 1'b1;
            end
            if (idx_last) begin
               idx_in   = '0;
               state_in = region_empty ? S_COMMIT : S_FILL_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_DEL_RD;
            end
         end
         S_FILL_RD: state_in = S_FILL_CHK;
         S_FILL_CHK: begin
            // clear the mark on the way through, ready for the next sweep
            map_we = 1'b1;
            if (map_rd[0]) begin
               if (cell_last) begin
                  state_in = S_COMMIT;
               end else begin
                  state_in = S_FILL_RD;
                  if (cell_last_c) begin
                     c0_in = '0;
                     r0_in = r0_ff + DIM_W'(1);
                  end else begin
                     c0_in = c0_ff + DIM_W'(1);
                  end
               end
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_FREE_RD: state_in = S_FREE_CHK;
         S_FREE_CHK: begin
            idx_in = idx_ff + IDX_W'(1);
            if (ent_rd.valid) begin
               state_in = S_FREE_RD;
            end else begin
               // lower slots are all taken, so the search resumes past this one
               ent_we = 1'b1;
               ent_wd = fill_word;
               if (cell_last) begin
                  state_in = S_COMMIT;
               end else begin
                  state_in = S_FILL_RD;
                  if (cell_last_c) begin
                     c0_in = '0;
                     r0_in = r0_ff + DIM_W'(1);
                  end else begin
                     c0_in = c0_ff + DIM_W'(1);
                  end
               end
            end
         end
         S_COMMIT: begin
            default_in = req_ff.value;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rows_ff      <= '0;
         cols_ff      <= '0;
         default_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         default_ff   <= default_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      req_ff        <= req_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_val_ff    <= hit_val_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      total_ff      <= total_in;
      kept_ff       <= kept_in;
      dels_ff       <= dels_in;
      area_ff       <= area_in;
      r0_ff         <= r0_in;
      c0_ff         <= c0_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // a transfer on the request side always starts a sequence
   `SMTS_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   // the default only moves once a set-default sweep has fully committed
   `SMTS_ASSERT_IMPL(a_default_on_commit, clock, reset, default_ff != $past(default_ff), $past(state_ff) == S_COMMIT)
   // the capacity check guarantees the fill sweep never runs off the table
   `SMTS_ASSERT_IMPL(a_fill_has_room, clock, reset, state_ff == S_FREE_CHK && ent_rd.valid, !idx_last)

endmodule
